### design/dfr_pkg.sv
// dfr_pkg: shared types and constants of the delimited frame receiver
// no dependencies; used by dfr_core, dfr_queue and delimited_frame_receiver
`default_nettype none

package dfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 13;
  localparam int unsigned HopW     = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned OutDataW = 56;

  localparam int unsigned MaxFrame  = 4096;
  localparam int unsigned QueueDepth = 4;

  // largest usable limit in the width of the limit register
  localparam logic [LenW-1:0] FrameCap =
    (MaxFrame > ((1 << LenW) - 1)) ? {LenW{1'b1}} : LenW'(MaxFrame);

  localparam logic [LenW-1:0] LimitReset = LenW'(4096);

  localparam logic [ByteW-1:0] ChBang = 8'h21;
  localparam logic [ByteW-1:0] ChAmp  = 8'h26;
  localparam logic [ByteW-1:0] ChHash = 8'h23;

  localparam logic [CfgIdxW-1:0] CfgHeaderMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameLimit = 1'b1;

  typedef enum logic [KindW-1:0] {
    KindPayload  = 2'd0,
    KindDone     = 2'd1,
    KindOverflow = 2'd2,
    KindShort    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhAmp  = 2'd1,
    PhRecv = 2'd2,
    PhStop = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data_byte;
    logic [LenW-1:0]   frame_length;
    logic [HopW-1:0]   next_hop;
    logic              last;
  } result_t;

  // results caused by one accepted byte
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

### design/dfr_core.sv
// dfr_core: configuration registers, frame state and per-byte result logic
// depends on dfr_pkg
`default_nettype none

module dfr_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dfr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_accept_i,
  input  wire logic [dfr_pkg::ByteW-1:0]     in_byte_i,
  output dfr_pkg::push_t                     push_o
);

  typedef struct packed {
    logic                        abort;
    logic                        emit;
    logic [dfr_pkg::LenW-1:0]    cnt;
    logic [dfr_pkg::HopW-1:0]    hop;
  } store_t;

  function automatic store_t store_f(
    input logic [dfr_pkg::ByteW-1:0] b,
    input logic [dfr_pkg::LenW-1:0]  cnt,
    input logic [dfr_pkg::HopW-1:0]  hop,
    input logic                      hm,
    input logic [dfr_pkg::LenW-1:0]  lim
  );
    store_t s;
    logic [dfr_pkg::LenW-1:0] c1;
    c1      = cnt + dfr_pkg::LenW'(1);
    s.abort = (cnt >= lim);
    s.emit  = 1'b0;
    s.cnt   = c1;
    s.hop   = hop;
    if (!s.abort) begin
      if (hm && (c1 <= dfr_pkg::LenW'(4))) begin
        s.hop = hop | ({24'b0, b} << {cnt[1:0], 3'b000});
      end else begin
        s.emit = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic dfr_pkg::result_t mk_res(
    input dfr_pkg::kind_e              kind,
    input logic [dfr_pkg::ByteW-1:0]   data,
    input logic [dfr_pkg::LenW-1:0]    len,
    input logic [dfr_pkg::HopW-1:0]    hop
  );
    dfr_pkg::result_t r;
    r.kind         = kind;
    r.data_byte    = data;
    r.frame_length = len;
    r.next_hop     = hop;
    r.last         = 1'b0;
    return r;
  endfunction

  logic                       header_mode_q;
  logic [dfr_pkg::LenW-1:0]   frame_limit_q;
  dfr_pkg::phase_e            phase_q, phase_d;
  logic [dfr_pkg::LenW-1:0]   cnt_q, cnt_d;
  logic [dfr_pkg::HopW-1:0]   hop_q, hop_d;

  logic [dfr_pkg::LenW-1:0]   lim;
  logic [dfr_pkg::ByteW-1:0]  first_byte;
  store_t                     s1, s2;
  dfr_pkg::result_t           second;
  logic                       second_valid;
  dfr_pkg::push_t             push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_mode_q <= 1'b0;
      frame_limit_q <= dfr_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfr_pkg::CfgHeaderMode: header_mode_q <= cfg_data_i[0];
        dfr_pkg::CfgFrameLimit: frame_limit_q <= cfg_data_i[dfr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dfr_pkg::PhHunt;
      cnt_q   <= '0;
      hop_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      hop_q   <= hop_d;
    end
  end

  // byte stores: the pending '!' in stop check, then the new byte
  always_comb begin
    lim        = (frame_limit_q > dfr_pkg::FrameCap) ? dfr_pkg::FrameCap : frame_limit_q;
    first_byte = (phase_q == dfr_pkg::PhStop) ? dfr_pkg::ChBang : in_byte_i;
    s1         = store_f(first_byte, cnt_q, hop_q, header_mode_q, lim);
    s2         = store_f(in_byte_i, s1.cnt, s1.hop, header_mode_q, lim);
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    hop_d   = hop_q;
    if (in_accept_i) begin
      unique case (phase_q)
        dfr_pkg::PhHunt: begin
          if (in_byte_i == dfr_pkg::ChBang) phase_d = dfr_pkg::PhAmp;
        end
        dfr_pkg::PhAmp: begin
          if (in_byte_i == dfr_pkg::ChAmp) begin
            phase_d = dfr_pkg::PhRecv;
            cnt_d   = '0;
            hop_d   = '0;
          end
        end
        dfr_pkg::PhRecv: begin
          if (in_byte_i == dfr_pkg::ChBang) begin
            phase_d = dfr_pkg::PhStop;
          end else if (s1.abort) begin
            phase_d = dfr_pkg::PhHunt;
            cnt_d   = '0;
            hop_d   = '0;
          end else begin
            cnt_d = s1.cnt;
            hop_d = s1.hop;
          end
        end
        dfr_pkg::PhStop: begin
          if ((in_byte_i == dfr_pkg::ChHash) || s1.abort) begin
            phase_d = dfr_pkg::PhHunt;
            cnt_d   = '0;
            hop_d   = '0;
          end else if (in_byte_i == dfr_pkg::ChBang) begin
            cnt_d = s1.cnt;
            hop_d = s1.hop;
          end else if (s2.abort) begin
            phase_d = dfr_pkg::PhHunt;
            cnt_d   = '0;
            hop_d   = '0;
          end else begin
            phase_d = dfr_pkg::PhRecv;
            cnt_d   = s2.cnt;
            hop_d   = s2.hop;
          end
        end
        default: ;
      endcase
    end
  end

  // results
  always_comb begin
    push         = '0;
    second       = '0;
    second_valid = 1'b0;
    if (s2.abort) begin
      second       = mk_res(dfr_pkg::KindOverflow, '0, '0, '0);
      second_valid = 1'b1;
    end else if (s2.emit) begin
      second       = mk_res(dfr_pkg::KindPayload, in_byte_i, '0, '0);
      second_valid = 1'b1;
    end
    if (in_accept_i) begin
      unique case (phase_q)
        dfr_pkg::PhRecv: begin
          if (in_byte_i != dfr_pkg::ChBang) begin
            if (s1.abort) begin
              push.r0  = mk_res(dfr_pkg::KindOverflow, '0, '0, '0);
              push.num = 2'd1;
            end else if (s1.emit) begin
              push.r0  = mk_res(dfr_pkg::KindPayload, in_byte_i, '0, '0);
              push.num = 2'd1;
            end
          end
        end
        dfr_pkg::PhStop: begin
          if (in_byte_i == dfr_pkg::ChHash) begin
            push.num = 2'd1;
            if (!header_mode_q) begin
              push.r0 = mk_res(dfr_pkg::KindDone, '0, cnt_q, '0);
            end else if (cnt_q < dfr_pkg::LenW'(4)) begin
              push.r0 = mk_res(dfr_pkg::KindShort, '0, '0, '0);
            end else begin
              push.r0 = mk_res(dfr_pkg::KindDone, '0, cnt_q - dfr_pkg::LenW'(4), hop_q);
            end
          end else if (s1.abort) begin
            push.r0  = mk_res(dfr_pkg::KindOverflow, '0, '0, '0);
            push.num = 2'd1;
          end else begin
            if (s1.emit) begin
              push.r0  = mk_res(dfr_pkg::KindPayload, dfr_pkg::ChBang, '0, '0);
              push.num = 2'd1;
            end
            if ((in_byte_i != dfr_pkg::ChBang) && second_valid) begin
              if (s1.emit) begin
                push.r1  = second;
                push.num = 2'd2;
              end else begin
                push.r0  = second;
                push.num = 2'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (push.num == 2'd2) begin
      push.r1.last = 1'b1;
    end else if (push.num == 2'd1) begin
      push.r0.last = 1'b1;
    end
  end

  assign push_o = push;

endmodule

`default_nettype wire

### design/dfr_queue.sv
// dfr_queue: result queue taking up to two results per cycle, one out per cycle while ready
// depends on dfr_pkg
`default_nettype none

module dfr_queue #(
  parameter int unsigned Depth = dfr_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dfr_pkg::push_t    push_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output dfr_pkg::result_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] inc_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  dfr_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, wr_next;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q <= CntW'(Depth - 2));
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign wr_next = inc_ptr(wr_q);

  always_comb begin
    unique case (push_i.num)
      2'd1:    wr_d = wr_next;
      2'd2:    wr_d = inc_ptr(wr_next);
      default: wr_d = wr_q;
    endcase
    rd_d  = pop ? inc_ptr(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire

### design/delimited_frame_receiver.sv
// delimited_frame_receiver: top level of the start/stop delimited byte deframer
// depends on dfr_pkg, dfr_core and dfr_queue
//
// One received byte is accepted per clock while the result queue has room for two
// results; its results are computed in the same cycle and written into a queue of
// QueueDepth entries that delivers one result per clock while the sink is ready. A byte gives at most two
// results (a given-back '!' plus the following byte), so the sustained rate is one
// byte per clock, less where such pairs occur or the sink stalls. Each result is
// registered in the queue before it reaches the output; results queued ahead of it or
// a stalled sink can hold it back further.
`default_nettype none

module delimited_frame_receiver #(
  parameter int unsigned QueueDepth = dfr_pkg::QueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dfr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [dfr_pkg::ByteW-1:0]     s_axis_tdata,   // in_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [dfr_pkg::OutDataW-1:0]       m_axis_tdata,   // data_byte, frame_length, next_hop
  output logic [dfr_pkg::KindW-1:0]          m_axis_tuser,   // kind
  output logic                               m_axis_tlast
);

  dfr_pkg::push_t   push;
  dfr_pkg::result_t head;
  logic             space;
  logic             in_accept;

  assign s_axis_tready = space;
  assign in_accept     = s_axis_tvalid && space;

  dfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push)
  );

  dfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {3'b000, head.next_hop, head.frame_length, head.data_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for delimited_frame_receiver, the start/stop byte deframer
// streams bytes in, takes each result from the directed table or its own deframer copy, checks the output stream
// depends on dfr_pkg and delimited_frame_receiver
module tb_top;
  import dfr_pkg::*;

  localparam int CycleLimit  = 2000000;
  localparam int ItemTarget  = 1850;
  localparam int DrainCycles = 4;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
    logic                typed;
    result_t             want;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  // deframer copy: configuration and frame state
  logic            cfg_hdr   = 1'b0;
  logic [LenW-1:0] cfg_limit = LimitReset;
  phase_e          fr_phase  = PhHunt;
  int              fr_count  = 0;
  logic [HopW-1:0] fr_hop    = '0;

  result_t step_res[$];
  result_t owed_q[$];

  int errors     = 0;
  int live_bytes = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_done     = 0;
  int n_abort    = 0;
  int cycles     = 0;
  bit src_burst  = 1'b0;
  bit sink_burst = 1'b0;

  delimited_frame_receiver i_dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("delimited_frame_receiver regression: fail");
      $finish;
    end
  end

  function automatic result_t mk_res(kind_e k, logic [ByteW-1:0] d, logic [LenW-1:0] len,
                                     logic [HopW-1:0] hop);
    result_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.frame_length = len;
    r.next_hop     = hop;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic void drop_frame();
    fr_phase = PhHunt;
    fr_count = 0;
    fr_hop   = '0;
  endfunction

  function automatic bit keep_byte(logic [ByteW-1:0] b);
    int cap;
    cap = (int'(cfg_limit) > int'(MaxFrame)) ? int'(MaxFrame) : int'(cfg_limit);
    if (fr_count + 1 > cap) begin
      step_res.push_back(mk_res(KindOverflow, '0, '0, '0));
      drop_frame();
      return 1'b0;
    end
    fr_count++;
    if (cfg_hdr && fr_count <= 4) fr_hop |= HopW'(b) << (8 * (fr_count - 1));
    else step_res.push_back(mk_res(KindPayload, b, '0, '0));
    return 1'b1;
  endfunction

  function automatic void deframe_byte(logic [ByteW-1:0] b);
    result_t r;
    step_res.delete();
    case (fr_phase)
      PhHunt: if (b == ChBang) fr_phase = PhAmp;
      PhAmp: if (b == ChAmp) begin
        fr_phase = PhRecv;
        fr_count = 0;
        fr_hop   = '0;
      end
      PhRecv: begin
        if (b == ChBang) fr_phase = PhStop;
        else void'(keep_byte(b));
      end
      default: begin
        if (b == ChHash) begin
          if (!cfg_hdr) step_res.push_back(mk_res(KindDone, '0, LenW'(fr_count), '0));
          else if (fr_count < 4) step_res.push_back(mk_res(KindShort, '0, '0, '0));
          else step_res.push_back(mk_res(KindDone, '0, LenW'(fr_count - 4), fr_hop));
          drop_frame();
        end else if (keep_byte(ChBang)) begin
          // a second bang keeps the stop check open
          if (b != ChBang && keep_byte(b)) fr_phase = PhRecv;
        end
      end
    endcase
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  function automatic stim_row_t row_b(logic [ByteW-1:0] b);
    stim_row_t s;
    s = '0;
    s.value = CfgDataW'(b);
    return s;
  endfunction

  function automatic stim_row_t row_t(logic [ByteW-1:0] b, kind_e k, logic [ByteW-1:0] d,
                                      logic [LenW-1:0] len, logic [HopW-1:0] hop);
    stim_row_t s;
    s = row_b(b);
    s.typed = 1'b1;
    s.want = mk_res(k, d, len, hop);
    s.want.last = 1'b1;
    return s;
  endfunction

  function automatic stim_row_t row_c(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.value = v;
    return s;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CfgDataW'(1);
      2: return CfgDataW'(4);
      3: return CfgDataW'(5);
      4: return LimitReset;
      5: return '1;
      default: return CfgDataW'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    if (idx == CfgHeaderMode) cfg_hdr = v[0];
    else cfg_limit = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed = 1'b0,
                           input result_t want = '0);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 59) == 0) src_burst = !src_burst;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
    if (!((fr_phase == PhHunt && b != ChBang) || (fr_phase == PhAmp && b != ChAmp)))
      live_bytes++;
    deframe_byte(b);
    if (typed) owed_q.push_back(want);
    else foreach (step_res[i]) owed_q.push_back(step_res[i]);
  endtask

  task automatic send_frame();
    int len;
    int cap;
    logic [ByteW-1:0] b;
    repeat ($urandom_range(0, 2)) send_byte(ByteW'($urandom_range(0, 255)));
    send_byte(ChBang);
    if ($urandom_range(0, 7) == 0) begin
      b = ByteW'($urandom_range(0, 255));
      send_byte(b == ChAmp ? ChHash : b);
    end
    send_byte(ChAmp);
    cap = int'(cfg_limit);
    if (cap <= 40 && $urandom_range(0, 2) == 0) len = $urandom_range(0, cap + 3);
    else len = $urandom_range(0, 12);
    repeat (len) send_byte($urandom_range(0, 9) == 0 ? ChBang : ByteW'($urandom_range(0, 255)));
    case ($urandom_range(0, 9))
      8: send_byte(ChBang);
      9: ;
      default: begin
        send_byte(ChBang);
        send_byte(ChHash);
      end
    endcase
  endtask

  task automatic check_result();
    result_t want;
    if (m_axis_tuser == KindDone) n_done++;
    if (m_axis_tuser == KindOverflow || m_axis_tuser == KindShort) n_abort++;
    n_checked++;
    if (owed_q.size() == 0) begin
      $error("result transfer with nothing owed: kind %0d data %02h",
             m_axis_tuser, m_axis_tdata[7:0]);
      errors++;
      return;
    end
    want = owed_q.pop_front();
    cmp_field("kind", 32'(want.kind), 32'(m_axis_tuser));
    cmp_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
    cmp_field("frame_length", 32'(want.frame_length), 32'(m_axis_tdata[20:8]));
    cmp_field("next_hop", want.next_hop, m_axis_tdata[52:21]);
    cmp_field("last", 32'(want.last), 32'(m_axis_tlast));
  endtask

  initial begin : sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      check_result();
    end
  end

  initial begin : stimulus
    stim_row_t dir_tab [0:37];
    dir_tab = '{
      // plain frame, bang pairs, wait for the amp mark
      row_b(ChBang), row_b(8'h41), row_b(ChAmp),
      row_t(8'h00, KindPayload, 8'h00, '0, '0),
      row_t(8'hFF, KindPayload, 8'hFF, '0, '0),
      row_b(ChBang), row_b(8'h55), row_b(ChBang),
      row_t(ChBang, KindPayload, ChBang, '0, '0),
      row_t(ChHash, KindDone, '0, LenW'(5), '0),
      // header mode: next hop, then a short frame
      row_c(CfgHeaderMode, CfgDataW'(1)),
      row_b(ChBang), row_b(ChAmp),
      row_b(8'h78), row_b(8'h56), row_b(8'h34), row_b(8'h12),
      row_t(8'hAA, KindPayload, 8'hAA, '0, '0),
      row_b(ChBang),
      row_t(ChHash, KindDone, '0, LenW'(1), 32'h1234_5678),
      row_b(ChBang), row_b(ChAmp), row_b(ChBang),
      row_t(ChHash, KindShort, '0, '0, '0),
      // overflow at limit 1, also on the second byte of a given-back pair
      row_c(CfgHeaderMode, '0),
      row_c(CfgFrameLimit, CfgDataW'(1)),
      row_b(ChBang), row_b(ChAmp),
      row_t(8'h7E, KindPayload, 8'h7E, '0, '0),
      row_t(8'h7F, KindOverflow, '0, '0, '0),
      row_b(ChBang), row_b(ChAmp), row_b(ChBang), row_b(8'h78),
      // zero limit aborts on the first stored byte
      row_c(CfgFrameLimit, '0),
      row_b(ChBang), row_b(ChAmp),
      row_t(8'h10, KindOverflow, '0, '0, '0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) apply_cfg(dir_tab[i].idx, dir_tab[i].value);
      else send_byte(dir_tab[i].value[ByteW-1:0], dir_tab[i].typed, dir_tab[i].want);
    end

    while (n_sent < ItemTarget) begin
      apply_cfg(CfgHeaderMode, CfgDataW'($urandom_range(0, 1)));
      apply_cfg(CfgFrameLimit, pick_limit());
      repeat ($urandom_range(3, 12)) begin
        send_frame();
        if ($urandom_range(0, 29) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("checked %0d result transfers for %0d input transfers, %0d of them in frames",
             n_checked, n_sent, live_bytes);
    $display("%0d frames closed, %0d aborted, with random limits, header mode and stalls",
             n_done, n_abort);
    if (errors == 0) begin
      $display("delimited_frame_receiver regression: pass");
    end else begin
      $display("delimited_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/dfr_pkg.sv
design/dfr_core.sv
design/dfr_queue.sv
design/delimited_frame_receiver.sv
bench/tb_top.sv
